@@ design/glc_pkg.sv @@
// shared types and constants for the graph local complementation unit
// no dependencies: compile before the design modules
package glc_pkg;

    localparam int ROWS             = 16;
    localparam int ROW_W            = 16;
    localparam int VTX_W            = 4;
    localparam int NUM_VERTICES_DEF = 16;

    // action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_APPLY = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [VTX_W-1:0] vertex;
        logic [ROW_W-1:0] row_bits;
        logic             color_in;
    } t_in_word;

    typedef struct packed {
        logic [ROW_W-1:0] row_out;
        logic             color_out;
        logic             same_as_initial;
    } t_out_word;

endpackage

@@ design/graph_local_complementation_unit.sv @@
// graph local complementation unit: adjacency matrix, colours and loaded copy
// depends on glc_pkg for word types, action codes and sizes
//
//  channel | direction | handshake                   | word
//  --------+-----------+-----------------------------+-------------------------
//  in      | into unit | i_in_valid / o_in_ready     | i_in_word  (t_in_word)
//  out     | from unit | o_out_valid / i_out_ready   | o_out_word (t_out_word)
//
// write and read words go through the accept step, then the result step
// an apply word goes through the accept step and a pivot row fetch, then the
// single row toggle unit sweeps one row a cycle, rewriting the neighbour rows
// the same_as_initial flag comes from a per-row mismatch vector kept up to date
// whenever a row is written, so no separate compare sweep is needed
// synchronous active-low reset clears the matrices, colours and control
// one result word is buffered, so a new word is taken while a result waits
module graph_local_complementation_unit #(
    parameter int NUM_VERTICES = glc_pkg::NUM_VERTICES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  glc_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output glc_pkg::t_out_word  o_out_word
);

    // only the low live vertices exist
    localparam int LIVE = (NUM_VERTICES > glc_pkg::ROWS) ? glc_pkg::ROWS : NUM_VERTICES;
    localparam logic [glc_pkg::ROW_W-1:0] LIVE_MASK =
        glc_pkg::ROW_W'((64'd1 << LIVE) - 64'd1);
    localparam logic [glc_pkg::VTX_W-1:0] LAST_IDX = glc_pkg::VTX_W'(LIVE - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PIVOT = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_FINAL = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // working and loaded copies of the graph
    logic [glc_pkg::ROW_W-1:0] r_adj  [glc_pkg::ROWS];
    logic [glc_pkg::ROW_W-1:0] r_init [glc_pkg::ROWS];
    logic [glc_pkg::ROWS-1:0]  r_colors;
    logic [glc_pkg::ROWS-1:0]  r_diff;      // row i differs from its loaded copy

    logic [glc_pkg::VTX_W-1:0] r_vertex;    // named vertex of the current word
    logic                      r_ok;        // named vertex is live
    logic [glc_pkg::VTX_W-1:0] r_idx;       // sweep row
    logic [glc_pkg::ROW_W-1:0] r_nbrs;      // neighbour set of the pivot

    logic                      r_out_valid;
    glc_pkg::t_out_word        r_out_word;

    logic                      accept;
    logic                      in_ok;
    logic [glc_pkg::VTX_W-1:0] rd_addr;
    logic [glc_pkg::ROW_W-1:0] rd_row;
    logic [glc_pkg::ROW_W-1:0] rd_init;
    logic [glc_pkg::ROW_W-1:0] self_bit;
    logic [glc_pkg::ROW_W-1:0] n_row;
    logic                      out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign in_ok       = {1'b0, i_in_word.vertex} < (glc_pkg::VTX_W + 1)'(LIVE);
    assign out_free    = !r_out_valid || i_out_ready;

    // single read port: sweep row while sweeping, otherwise the named vertex
    assign rd_addr = (r_state == ST_SWEEP) ? r_idx : r_vertex;
    assign rd_row  = r_adj[rd_addr];
    assign rd_init = r_init[rd_addr];

    // row toggle unit: flip every other neighbour in a neighbour's row
    assign self_bit = glc_pkg::ROW_W'(1) << r_idx;
    assign n_row    = rd_row ^ (r_nbrs & ~self_bit);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (in_ok && i_in_word.action == glc_pkg::ACT_APPLY) begin
                        n_state = ST_PIVOT;
                    end else begin
                        n_state = ST_FINAL;
                    end
                end
            end
            ST_PIVOT: n_state = ST_SWEEP;
            ST_SWEEP: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_colors    <= '0;
            r_diff      <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_ok        <= 1'b0;
            for (int i = 0; i < glc_pkg::ROWS; i++) begin
                r_adj[i]  <= '0;
                r_init[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            // output register: loaded from the final step, emptied when taken
            if (r_state == ST_FINAL && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_vertex <= i_in_word.vertex;
                        r_ok     <= in_ok;
                        r_idx    <= '0;
                        // a write loads both copies at once
                        if (in_ok && i_in_word.action == glc_pkg::ACT_WRITE) begin
                            r_adj[i_in_word.vertex]    <= i_in_word.row_bits & LIVE_MASK;
                            r_init[i_in_word.vertex]   <= i_in_word.row_bits & LIVE_MASK;
                            r_diff[i_in_word.vertex]   <= 1'b0;
                            r_colors[i_in_word.vertex] <= i_in_word.color_in;
                        end
                    end
                end
                ST_PIVOT: begin
                    r_nbrs   <= rd_row & LIVE_MASK;
                    r_colors <= r_colors ^ (rd_row & LIVE_MASK);
                end
                ST_SWEEP: begin
                    if (r_nbrs[r_idx]) begin
                        r_adj[r_idx]  <= n_row;
                        r_diff[r_idx] <= (n_row != rd_init);
                    end
                    r_idx <= r_idx + 1'b1;
                end
                ST_FINAL: begin
                    if (out_free) begin
                        r_out_word.row_out         <= r_ok ? rd_row : '0;
                        r_out_word.color_out       <= r_ok ? r_colors[r_vertex] : 1'b0;
                        r_out_word.same_as_initial <= ~|r_diff;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // the sweep never touches a row beyond the live vertices
    a_sweep_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> ({1'b0, r_idx} < (glc_pkg::VTX_W + 1)'(LIVE)))
        else $error("sweep row beyond live vertices");

    // a result only appears out of the final step
    a_result_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_FINAL))
        else $error("result raised outside final step");

    // a live write leaves that row matching its loaded copy
    a_write_clears_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_ok && i_in_word.action == glc_pkg::ACT_WRITE)
        |=> !r_diff[$past(i_in_word.vertex)])
        else $error("write left row marked as differing");

    // an apply word on a live pivot always goes through the pivot fetch
    a_apply_fetches_pivot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_ok && i_in_word.action == glc_pkg::ACT_APPLY)
        |=> (r_state == ST_PIVOT))
        else $error("apply skipped pivot fetch");

endmodule
